@@ rtl/core/latency_histogram_percentile_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the latency histogram block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_PERCENTILE_DEFINES_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_DEFINES_SVH

// Same-cycle implication
`define LHP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lhp: same-cycle check failed");

// Next-cycle implication
`define LHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lhp: next-cycle check failed");

`endif

@@ rtl/core/lhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared widths, command codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package lhp_pkg;

  localparam int CMD_W     = 2;
  localparam int BOUND_W   = 24;
  localparam int Q_W       = 17;
  localparam int Q_FRAC    = 16;
  localparam int BKT_W     = 4;
  localparam int PCT_W     = 25;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_REGS  = 8;
  localparam int PROD_W    = CNT_W + Q_W;
  localparam int TGT_W     = PROD_W - Q_FRAC;
  // nine 32-bit counts summed
  localparam int CUM_W     = CNT_W + 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [Q_W-1:0]   Q_ONE   = Q_W'(1) << Q_FRAC;

  localparam logic [BOUND_W-1:0] BOUND_RESET [NUM_REGS] = '{
    24'd1, 24'd5, 24'd10, 24'd50, 24'd100, 24'd500, 24'd1000, 24'd5000
  };

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic rec_commit;
    logic qry_start;
    logic cum_acc;
    logic pct_set;
    logic clear;
    logic out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;
    logic bound_last;
    logic reach;
    logic walk_last;
    logic empty;
  } dp_stat_t;

endpackage

@@ rtl/core/lhp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhp channel interfaces
// Sample/command input, result output and bound register write channels.
// ----------------------------------------------------------------------------

// Command and sample input channel
interface lhp_in_if;
  logic                        valid;
  logic                        ready;
  logic [lhp_pkg::CMD_W-1:0]   cmd;
  logic [lhp_pkg::BOUND_W-1:0] lat_ms;
  logic [lhp_pkg::Q_W-1:0]     quantile;

  modport source (output valid, cmd, lat_ms, quantile, input ready);
  modport sink   (input valid, cmd, lat_ms, quantile, output ready);
endinterface

// Result channel
interface lhp_out_if;
  logic                      valid;
  logic                      ready;
  logic [lhp_pkg::BKT_W-1:0] bucket_hit;
  logic [lhp_pkg::PCT_W-1:0] percentile_ms;
  logic [lhp_pkg::CNT_W-1:0] sample_count;
  logic [lhp_pkg::SUM_W-1:0] latency_sum;

  modport source (output valid, bucket_hit, percentile_ms, sample_count, latency_sum,
                  input ready);
  modport sink   (input valid, bucket_hit, percentile_ms, sample_count, latency_sum,
                  output ready);
endinterface

// Bound register write channel
interface lhp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lhp_pkg::CFG_IDX_W-1:0] index;
  logic [lhp_pkg::BOUND_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/lhp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhp_ctrl
// Sequencer: bound search for record, target walk for query, clear, and
// hand-off of the result beat to the output register.
// ----------------------------------------------------------------------------
module lhp_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lhp_pkg::CMD_W-1:0] cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  lhp_pkg::dp_stat_t         stat,
  output lhp_pkg::ctl_cmd_t         ctl
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_SEARCH,
    ST_REC_UPD,
    ST_QRY_MUL,
    ST_QRY_WALK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load    = 1'b1;
          ctl.idx_clr = 1'b1;
          case (lhp_pkg::cmd_t'(cmd))
            lhp_pkg::CMD_RECORD: state_next = ST_REC_SEARCH;
            lhp_pkg::CMD_QUERY:  state_next = ST_QRY_MUL;
            lhp_pkg::CMD_CLEAR:  state_next = ST_CLEAR;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_REC_SEARCH: begin
        // one bound compared per cycle; no match past the last goes to overflow
        if (stat.match) begin
          state_next = ST_REC_UPD;
        end else if (stat.bound_last) begin
          ctl.idx_inc = 1'b1;
          state_next  = ST_REC_UPD;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      ST_REC_UPD: begin
        ctl.rec_commit = 1'b1;
        state_next     = ST_DONE;
      end
      ST_QRY_MUL: begin
        ctl.qry_start = 1'b1;
        state_next    = stat.empty ? ST_DONE : ST_QRY_WALK;
      end
      ST_QRY_WALK: begin
        ctl.cum_acc = 1'b1;
        if (stat.reach) begin
          ctl.pct_set = 1'b1;
          state_next  = ST_DONE;
        end else if (stat.walk_last) begin
          state_next = ST_DONE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      ST_CLEAR: begin
        ctl.clear  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/lhp_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhp_dp
// Bound registers, bucket counters, totals, query target multiply,
// cumulative walk and the output register.
// ----------------------------------------------------------------------------
module lhp_dp #(
  parameter int NUM_BOUNDS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lhp_pkg::ctl_cmd_t             ctl,
  output lhp_pkg::dp_stat_t             stat,
  input  logic                          cfg_we,
  input  logic [lhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lhp_pkg::BOUND_W-1:0]   cfg_data,
  input  logic [lhp_pkg::BOUND_W-1:0]   lat_ms,
  input  logic [lhp_pkg::Q_W-1:0]       quantile,
  output logic [lhp_pkg::BKT_W-1:0]     bucket_hit,
  output logic [lhp_pkg::PCT_W-1:0]     percentile_ms,
  output logic [lhp_pkg::CNT_W-1:0]     sample_count,
  output logic [lhp_pkg::SUM_W-1:0]     latency_sum
);

  localparam int IDX_W = $clog2(NUM_BOUNDS + 1);
  localparam int BND_W = (NUM_BOUNDS > 1) ? $clog2(NUM_BOUNDS) : 1;
  localparam logic [IDX_W-1:0] IDX_OVF  = IDX_W'(NUM_BOUNDS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BOUNDS - 1);

  logic [lhp_pkg::BOUND_W-1:0] bounds [NUM_BOUNDS];
  logic [lhp_pkg::CNT_W-1:0]   counts [NUM_BOUNDS+1];
  logic [lhp_pkg::CNT_W-1:0]   total;
  logic [lhp_pkg::SUM_W-1:0]   sum;
  logic [lhp_pkg::BOUND_W-1:0] lat;
  logic [lhp_pkg::Q_W-1:0]     q;
  logic [IDX_W-1:0]            idx;
  logic [lhp_pkg::CUM_W-1:0]   cum;
  logic [lhp_pkg::TGT_W-1:0]   target;
  logic [lhp_pkg::BKT_W-1:0]   res_hit;
  logic [lhp_pkg::PCT_W-1:0]   res_pct;

  logic [lhp_pkg::BOUND_W-1:0] bound_sel;
  logic [lhp_pkg::CNT_W-1:0]   count_sel;
  logic [lhp_pkg::CUM_W-1:0]   cum_sum;
  logic [lhp_pkg::CNT_W-1:0]   count_bump;
  logic [lhp_pkg::CNT_W-1:0]   total_bump;
  logic [lhp_pkg::SUM_W:0]     sum_add;
  logic [lhp_pkg::SUM_W-1:0]   sum_sat;
  logic [lhp_pkg::PROD_W-1:0]  prod;

  // shared read port at the walk index
  assign bound_sel = bounds[idx[BND_W-1:0]];
  assign count_sel = counts[idx];
  assign cum_sum   = cum + lhp_pkg::CUM_W'(count_sel);

  // saturating updates
  assign count_bump = (count_sel == lhp_pkg::CNT_MAX) ? lhp_pkg::CNT_MAX
                                                      : count_sel + lhp_pkg::CNT_W'(1);
  assign total_bump = (total == lhp_pkg::CNT_MAX) ? lhp_pkg::CNT_MAX
                                                  : total + lhp_pkg::CNT_W'(1);
  assign sum_add    = {1'b0, sum} + (lhp_pkg::SUM_W + 1)'(lat);
  assign sum_sat    = sum_add[lhp_pkg::SUM_W] ? lhp_pkg::SUM_MAX
                                              : sum_add[lhp_pkg::SUM_W-1:0];

  // target = floor(count * p)
  assign prod = lhp_pkg::PROD_W'(total) * lhp_pkg::PROD_W'(q);

  // status
  assign stat.match      = (lat <= bound_sel);
  assign stat.bound_last = (idx == IDX_LAST);
  assign stat.reach      = (cum_sum >= lhp_pkg::CUM_W'(target));
  assign stat.walk_last  = (idx == IDX_OVF);
  assign stat.empty      = (total == '0);

  // bound registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        bounds[i] <= lhp_pkg::BOUND_RESET[i];
      end
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        if (cfg_index == lhp_pkg::CFG_IDX_W'(i)) begin
          bounds[i] <= cfg_data;
        end
      end
    end
  end

  // histogram store and totals
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i <= NUM_BOUNDS; i++) begin
        counts[i] <= '0;
      end
      total <= '0;
      sum   <= '0;
    end else if (ctl.rec_commit) begin
      counts[idx] <= count_bump;
      total       <= total_bump;
      sum         <= sum_sat;
    end
  end

  // walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.idx_clr || ctl.qry_start) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // operands, query target, cumulative count and result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lat     <= lat_ms;
      q       <= (quantile > lhp_pkg::Q_ONE) ? lhp_pkg::Q_ONE : quantile;
      res_hit <= '0;
      res_pct <= '0;
    end
    if (ctl.qry_start) begin
      target <= prod[lhp_pkg::PROD_W-1:lhp_pkg::Q_FRAC];
      cum    <= '0;
    end else if (ctl.cum_acc) begin
      cum <= cum_sum;
    end
    if (ctl.rec_commit) begin
      res_hit <= lhp_pkg::BKT_W'(idx);
    end
    if (ctl.pct_set) begin
      // overflow bucket reports twice the last bound
      res_pct <= (idx == IDX_OVF) ? {bounds[NUM_BOUNDS-1], 1'b0} : {1'b0, bound_sel};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      bucket_hit    <= res_hit;
      percentile_ms <= res_pct;
      sample_count  <= total;
      latency_sum   <= sum;
    end
  end

endmodule

@@ rtl/core/latency_histogram_percentile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_histogram_percentile
// Bucketed latency histogram with saturating counters and percentile query.
// ----------------------------------------------------------------------------
// Each input beat carries one command and yields exactly one result beat.
// A record scans the bounds one per cycle, then bumps its bucket and the
// totals. A query multiplies the count by p, then walks the bucket counts
// one per cycle; when no samples are held it skips the walk. The bound scan
// and the bucket walk share one index into the counter array, so one item is
// in work at a time; a finished result waits in the output register while
// the next beat is accepted. Bound writes are taken at any cycle (ready is
// always high); bound registers beyond NUM_BOUNDS are ignored.
// ----------------------------------------------------------------------------
`include "latency_histogram_percentile_defines.svh"

module latency_histogram_percentile #(
  parameter int NUM_BOUNDS = 8
) (
  input  logic       clk,
  input  logic       rst,
  lhp_in_if.sink     sample_in,
  lhp_out_if.source  result_out,
  lhp_cfg_if.sink    cfg
);

  lhp_pkg::ctl_cmd_t ctl_cmd;
  lhp_pkg::dp_stat_t dp_stat;
  logic              cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  lhp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .cmd       (sample_in.cmd),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .stat      (dp_stat),
    .ctl       (ctl_cmd)
  );

  lhp_dp #(
    .NUM_BOUNDS (NUM_BOUNDS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl_cmd),
    .stat          (dp_stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .lat_ms        (sample_in.lat_ms),
    .quantile      (sample_in.quantile),
    .bucket_hit    (result_out.bucket_hit),
    .percentile_ms (result_out.percentile_ms),
    .sample_count  (result_out.sample_count),
    .latency_sum   (result_out.latency_sum)
  );

  // output register is never loaded over an untaken result
  `LHP_ASSERT_IMPL(a_no_overwrite, ctl_cmd.out_load, !result_out.valid || result_out.ready)
  // one item in work at a time
  `LHP_ASSERT_NEXT(a_one_in_work, sample_in.valid && sample_in.ready, !sample_in.ready)
  // a result carries a bucket or a percentile, never both
  `LHP_ASSERT_IMPL(a_hit_xor_pct, result_out.valid && result_out.bucket_hit != '0,
                   result_out.percentile_ms == '0)

endmodule
